// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

  localparam int unsigned ScreenColumnsDef = 80;
  localparam int unsigned ScreenRowsDef    = 30;

  localparam int unsigned CodeW = 8;
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 7;

  localparam logic [CodeW-1:0] CodeNewline = 8'd10;
  localparam logic [CodeW-1:0] CodeSpace   = 8'h20;

  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_READ = 1'b1
  } action_e;

endpackage

`default_nettype wire

// ----- rtl/text_console_writer_core.sv -----
// Channel  Direction  Beat contents
// -------  ---------  -----------------------------------------------------
// in       sink       action, char_code, read_row, read_col
// out      source     cell_data, cursor_column, cursor_line
//
// A read steps the sequencer through EXEC, RWAIT and DONE, a put through EXEC
// and DONE; the next beat is accepted once DONE has loaded the result into
// the output register.
// A put that moves the cursor past the last row passes through BLANK first,
// in which the sequencer blanks the new bottom row one cell per cycle
// through the single write port of the screen memory.
// After reset a clearing pass fills all SCREEN_ROWS * SCREEN_COLUMNS cells
// (2400 at the defaults) with spaces, one cell per cycle; no beat is
// accepted until it has finished.
// A finished result waits in the output register; the next input beat is
// accepted meanwhile, and the sequencer holds only if a second result is
// ready before the first has been taken.

`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumnsDef,
  parameter int unsigned SCREEN_ROWS    = ScreenRowsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             action_i,
  input  wire logic [CodeW-1:0] char_code_i,
  input  wire logic [RowW-1:0]  read_row_i,
  input  wire logic [ColW-1:0]  read_col_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CodeW-1:0]      cell_data_o,
  output logic [ColW-1:0]       cursor_column_o,
  output logic [RowW-1:0]       cursor_line_o
);

  // Rows are addressed physically through a rotating top-row pointer, so a
  // scroll never copies the screen: it advances the pointer and blanks the
  // row that has become the bottom one. Each row occupies a power-of-two
  // slot in the memory so that an address is simply {row, column}.
  localparam int unsigned RW       = $clog2(SCREEN_ROWS);
  localparam int unsigned CW       = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam int unsigned AW       = RW + CW;
  localparam int unsigned MemDepth = SCREEN_ROWS << CW;

  localparam logic [RW-1:0] RowLast = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] ColLast = CW'(SCREEN_COLUMNS - 1);
  localparam logic [RW:0]   RowsExt = (RW + 1)'(SCREEN_ROWS);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_RWAIT = 6'b001000,
    S_BLANK = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Latched input beat.
  logic             action_q, action_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic             in_range_q, in_range_d;

  // Cursor and scroll pointer.
  logic [CW-1:0] cursor_col_q, cursor_col_d;
  logic [RW-1:0] cursor_row_q, cursor_row_d;
  logic [RW-1:0] top_q, top_d;

  // Row fill engine, used by the clearing pass and by scrolling.
  logic [RW-1:0] fill_row_q, fill_row_d;
  logic [CW-1:0] fill_col_q, fill_col_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] cell_data_q, cell_data_d;
  logic [CW-1:0]    out_col_q, out_col_d;
  logic [RW-1:0]    out_row_q, out_row_d;

  // Screen memory.
  logic [CodeW-1:0] mem_q [MemDepth];
  logic [CodeW-1:0] rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CodeW-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  // Shared logical-to-physical row unit: one add, one compare and subtract.
  logic [RW-1:0] log_row;
  logic [RW:0]   row_sum;
  logic [RW-1:0] phys_row;

  logic in_fire, out_load, is_newline, last_col, adv_row;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign log_row  = (action_q == ACT_READ) ? row_q : cursor_row_q;
  assign row_sum  = {1'b0, top_q} + {1'b0, log_row};
  assign phys_row = (row_sum >= RowsExt) ? RW'(row_sum - RowsExt) : row_sum[RW-1:0];

  assign is_newline = (code_q == CodeNewline);
  assign last_col   = (cursor_col_q == ColLast);
  assign adv_row    = is_newline || last_col;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {fill_row_q, fill_col_q};
    mem_wdata = CodeSpace;
    if (state_q == S_CLEAR || state_q == S_BLANK) begin
      mem_we = 1'b1;
    end else if (state_q == S_EXEC && action_q == ACT_PUT && !is_newline) begin
      mem_we    = 1'b1;
      mem_waddr = {phys_row, cursor_col_q};
      mem_wdata = code_q;
    end
  end

  assign mem_re    = (state_q == S_EXEC) && (action_q == ACT_READ) && in_range_q;
  assign mem_raddr = {phys_row, col_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d      = state_q;
    action_d     = action_q;
    code_d       = code_q;
    row_d        = row_q;
    col_d        = col_q;
    in_range_d   = in_range_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    top_d        = top_q;
    fill_row_d   = fill_row_q;
    fill_col_d   = fill_col_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cell_data_d  = cell_data_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;

    unique case (state_q)
      S_CLEAR: begin
        if (fill_col_q == ColLast) begin
          fill_col_d = '0;
          if (fill_row_q == RowLast) begin
            state_d = S_IDLE;
          end else begin
            fill_row_d = fill_row_q + 1'b1;
          end
        end else begin
          fill_col_d = fill_col_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          action_d   = action_i;
          code_d     = char_code_i;
          row_d      = RW'(read_row_i);
          col_d      = CW'(read_col_i);
          in_range_d = (32'(read_row_i) < SCREEN_ROWS) &&
                       (32'(read_col_i) < SCREEN_COLUMNS);
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (action_q == ACT_READ) begin
          state_d = S_RWAIT;
        end else begin
          state_d = S_DONE;
          if (adv_row) begin
            cursor_col_d = '0;
            if (cursor_row_q == RowLast) begin
              // Scroll: the old top row becomes the new, blank bottom row.
              top_d      = (top_q == RowLast) ? '0 : top_q + 1'b1;
              fill_row_d = top_q;
              fill_col_d = '0;
              state_d    = S_BLANK;
            end else begin
              cursor_row_d = cursor_row_q + 1'b1;
            end
          end else begin
            cursor_col_d = cursor_col_q + 1'b1;
          end
        end
      end
      S_RWAIT: begin
        state_d = S_DONE;
      end
      S_BLANK: begin
        if (fill_col_q == ColLast) begin
          state_d = S_DONE;
        end else begin
          fill_col_d = fill_col_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          cell_data_d = (action_q == ACT_READ && in_range_q) ? rdata_q : '0;
          out_col_d   = cursor_col_q;
          out_row_d   = cursor_row_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      top_q        <= '0;
      fill_row_q   <= '0;
      fill_col_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      top_q        <= top_d;
      fill_row_q   <= fill_row_d;
      fill_col_q   <= fill_col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q    <= action_d;
    code_q      <= code_d;
    row_q       <= row_d;
    col_q       <= col_d;
    in_range_q  <= in_range_d;
    cell_data_q <= cell_data_d;
    out_col_q   <= out_col_d;
    out_row_q   <= out_row_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cell_data_o     = cell_data_q;
  assign cursor_column_o = ColW'(out_col_q);
  assign cursor_line_o   = RowW'(out_row_q);

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
`include "assert_macros.svh"

`default_nettype none

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumnsDef,
  parameter int unsigned SCREEN_ROWS    = ScreenRowsDef
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [CodeW-1:0] cell_data_o,
  input wire logic [ColW-1:0]  cursor_column_o,
  input wire logic [RowW-1:0]  cursor_line_o
);

  logic in_fire, out_stall;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // One item at a time: the sequencer is busy in the cycle after a beat.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o, "ready after accept")

  // A result never appears in the cycle right after its input beat.
  `ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_fire && !out_valid_o, !out_valid_o, "early result")

  // A stalled result stays offered with the same contents.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
    out_valid_o && $stable(cell_data_o) && $stable(cursor_column_o) && $stable(cursor_line_o),
    "stalled result changed")

  // The reported cursor always lies on the screen.
  `ASSERT_ALWAYS(a_cursor_on_screen, clk_i, rst_ni,
    !out_valid_o || (32'(cursor_column_o) < SCREEN_COLUMNS && 32'(cursor_line_o) < SCREEN_ROWS),
    "cursor off screen")

endmodule

bind text_console_writer_core tcw_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS),
  .SCREEN_ROWS   (SCREEN_ROWS)
) u_tcw_checker (.*);

`default_nettype wire
